### sv/tccw_pkg.sv
package tccw_pkg;

    // Default screen geometry limits
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 32;

    // Field widths fixed by the interface
    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int ATTR_W      = 8;
    localparam int COLUMNS_W   = 8;
    localparam int ROWS_W      = 6;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int REQ_W       = 2;
    localparam int POS_X_W     = 7;
    localparam int POS_Y_W     = 5;
    localparam int LOC_W       = 12;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT        = 2'd0,
        REQ_SET_CURSOR = 2'd1,
        REQ_CLEAR      = 2'd2,
        REQ_READ       = 2'd3
    } req_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_ATTR  = 2'd2;

    // Register reset values
    localparam logic [COLUMNS_W-1:0] COLUMNS_RST    = 8'd80;
    localparam logic [ROWS_W-1:0]    ROWS_RST       = 6'd25;
    localparam logic [ATTR_W-1:0]    BLANK_ATTR_RST = 8'h07;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Pack a cell as {attribute, character}
    function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                    input logic [CHAR_W-1:0] ch);
        make_cell = {attr, ch};
    endfunction

endpackage

### sv/tccw_ram.sv
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/tccw_mac.sv
module tccw_mac #(
    parameter int A_W = 6,
    parameter int B_W = 8,
    parameter int C_W = 7,
    parameter int P_W = 13
)(
    input  logic           clk,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    input  logic [C_W-1:0] c,
    output logic [P_W-1:0] p
);

    // Shared row * columns + column unit, result registered
    logic [P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= P_W'(P_W'(a) * P_W'(b) + P_W'(c));
    end

    assign p = p_reg;

endmodule

### sv/text_console_cell_writer_core.sv
// Sequence: a request is decoded, then a plain character passes the write state, read cell the
// read address and read wait states, clear setup and fill, scroll setup, copy, drain and fill
// (setup and fill on a one-row screen); all end in the location and result states. A request
// is taken only when idle. Scroll copies one cell a cycle through the single RAM port pair.
// Reset (rst_n low, asynchronous): cursor to 0,0, registers to 80 columns, 25 rows,
// attribute 0x07; screen cells undefined until written. Results cannot be stalled.
module text_console_cell_writer_core
    import tccw_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    // command side
    input  logic                   start,
    output logic                   busy,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [COLOR_W-1:0]     fg_color,
    input  logic [COLOR_W-1:0]     bg_color,
    input  logic [POS_X_W-1:0]     pos_x,
    input  logic [POS_Y_W-1:0]     pos_y,
    // result side
    output logic                   done,
    output logic [POS_X_W-1:0]     cursor_x,
    output logic [POS_Y_W-1:0]     cursor_y,
    output logic [LOC_W-1:0]       cursor_location,
    output logic [CELL_W-1:0]      cell_word,
    output logic                   scrolled,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int LIN_W  = $clog2(CELLS + 1);
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_SETUP,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_READ_ADDR,
        ST_READ_WAIT,
        ST_LOC,
        ST_RESULT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COLUMNS_W-1:0] columns_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [ATTR_W-1:0]    blank_attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= COLUMNS_RST;
            rows_reg       <= ROWS_RST;
            blank_attr_reg <= BLANK_ATTR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:    columns_reg    <= COLUMNS_W'(cfg_data);
                CFG_ROWS:       rows_reg       <= ROWS_W'(cfg_data);
                CFG_BLANK_ATTR: blank_attr_reg <= ATTR_W'(cfg_data);
                default:        ; // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective geometry: registers saturated to 1..MAX
    // ------------------------------------------------------------------
    logic [CCNT_W-1:0] eff_cols;
    logic [RCNT_W-1:0] eff_rows;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;

    always_comb
    begin
        if (columns_reg == '0)
            eff_cols = CCNT_W'(1);
        else if (int'(columns_reg) > MAX_COLUMNS)
            eff_cols = CCNT_W'(MAX_COLUMNS);
        else
            eff_cols = CCNT_W'(columns_reg);

        if (rows_reg == '0)
            eff_rows = RCNT_W'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            eff_rows = RCNT_W'(MAX_ROWS);
        else
            eff_rows = RCNT_W'(rows_reg);
    end

    assign last_col = COL_W'(eff_cols - CCNT_W'(1));
    assign last_row = ROW_W'(eff_rows - RCNT_W'(1));

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t              state_reg;
    req_t                req_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [ATTR_W-1:0]   attr_reg;
    logic [COL_W-1:0]    px_reg;
    logic [ROW_W-1:0]    py_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic                scrolled_reg;
    logic [ADDR_W-1:0]   src_reg;
    logic [ADDR_W-1:0]   dst_reg;
    logic [ADDR_W-1:0]   total_m1_reg;
    logic                pipe_valid_reg;
    logic [ADDR_W-1:0]   pipe_addr_reg;

    // Cursor and position saturated to the screen at the start of each word
    logic [COL_W-1:0] sat_col;
    logic [ROW_W-1:0] sat_row;
    logic [COL_W-1:0] sat_px;
    logic [ROW_W-1:0] sat_py;

    assign sat_col = (col_reg > last_col) ? last_col : col_reg;
    assign sat_row = (row_reg > last_row) ? last_row : row_reg;
    assign sat_px  = (int'(pos_x) > int'(last_col)) ? last_col : COL_W'(pos_x);
    assign sat_py  = (int'(pos_y) > int'(last_row)) ? last_row : ROW_W'(pos_y);

    logic at_last_col;
    logic at_last_row;

    assign at_last_col = (col_reg == last_col);
    assign at_last_row = (row_reg == last_row);

    // ------------------------------------------------------------------
    // Shared multiply-add: cell address, screen size and cursor location
    // ------------------------------------------------------------------
    logic [RCNT_W-1:0] mac_a;
    logic [COL_W-1:0]  mac_c;
    logic [LIN_W-1:0]  mac_q;

    always_comb
    begin
        mac_a = RCNT_W'(row_reg);
        mac_c = col_reg;
        case (state_reg)
            ST_DECODE:
            begin
                if (req_reg == REQ_READ)
                begin
                    mac_a = RCNT_W'(py_reg);
                    mac_c = px_reg;
                end
                else if (req_reg == REQ_CLEAR ||
                         (req_reg == REQ_PUT && char_reg == CHAR_LF))
                begin
                    // screen size, for a clear or a possible scroll
                    mac_a = eff_rows;
                    mac_c = '0;
                end
            end
            ST_WRITE:
            begin
                mac_a = eff_rows;
                mac_c = '0;
            end
            default: ;
        endcase
    end

    tccw_mac #(
        .A_W (RCNT_W),
        .B_W (CCNT_W),
        .C_W (COL_W),
        .P_W (LIN_W)
    ) u_mac (
        .clk (clk),
        .a   (mac_a),
        .b   (eff_cols),
        .c   (mac_c),
        .p   (mac_q)
    );

    // ------------------------------------------------------------------
    // Screen memory
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Copy writes land in the cycle after their reads; fill and put use the port otherwise
    always_comb
    begin
        ram_we = pipe_valid_reg || (state_reg == ST_FILL) || (state_reg == ST_WRITE);
        if (pipe_valid_reg)
        begin
            ram_waddr = pipe_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (state_reg == ST_FILL)
        begin
            ram_waddr = dst_reg;
            ram_wdata = make_cell(blank_attr_reg, CHAR_SPACE);
        end
        else
        begin
            ram_waddr = ADDR_W'(mac_q);
            ram_wdata = make_cell(attr_reg, char_reg);
        end
        ram_raddr = (state_reg == ST_COPY) ? src_reg : ADDR_W'(mac_q);
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= (state_reg == ST_COPY);
            pipe_addr_reg  <= dst_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg      <= req_t'(req_type);
                        char_reg     <= char_code;
                        attr_reg     <= {bg_color, fg_color};
                        px_reg       <= sat_px;
                        py_reg       <= sat_py;
                        col_reg      <= sat_col;
                        row_reg      <= sat_row;
                        cell_reg     <= '0;
                        scrolled_reg <= 1'b0;
                        state_reg    <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    unique case (req_reg)
                        REQ_PUT:
                        begin
                            if (char_reg == CHAR_LF)
                            begin
                                col_reg <= '0;
                                if (at_last_row)
                                begin
                                    scrolled_reg <= 1'b1;
                                    state_reg    <= ST_SETUP;
                                end
                                else
                                begin
                                    row_reg   <= row_reg + ROW_W'(1);
                                    state_reg <= ST_LOC;
                                end
                            end
                            else if (char_reg == CHAR_CR)
                            begin
                                col_reg   <= '0;
                                state_reg <= ST_LOC;
                            end
                            else
                            begin
                                state_reg <= ST_WRITE;
                            end
                        end
                        REQ_SET_CURSOR:
                        begin
                            col_reg   <= px_reg;
                            row_reg   <= py_reg;
                            state_reg <= ST_LOC;
                        end
                        REQ_CLEAR: state_reg <= ST_SETUP;
                        REQ_READ:  state_reg <= ST_READ_ADDR;
                        default:   state_reg <= ST_LOC;
                    endcase
                end
                ST_WRITE:
                begin
                    // cell goes to memory this cycle; advance with wrap
                    cell_reg <= make_cell(attr_reg, char_reg);
                    if (at_last_col)
                    begin
                        col_reg <= '0;
                        if (at_last_row)
                        begin
                            scrolled_reg <= 1'b1;
                            state_reg    <= ST_SETUP;
                        end
                        else
                        begin
                            row_reg   <= row_reg + ROW_W'(1);
                            state_reg <= ST_LOC;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + COL_W'(1);
                        state_reg <= ST_LOC;
                    end
                end
                ST_SETUP:
                begin
                    total_m1_reg <= ADDR_W'(mac_q - LIN_W'(1));
                    dst_reg      <= '0;
                    src_reg      <= ADDR_W'(eff_cols);
                    if (req_reg == REQ_CLEAR || eff_rows == RCNT_W'(1))
                        state_reg <= ST_FILL;
                    else
                        state_reg <= ST_COPY;
                end
                ST_COPY:
                begin
                    src_reg <= src_reg + ADDR_W'(1);
                    dst_reg <= dst_reg + ADDR_W'(1);
                    if (src_reg == total_m1_reg)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FILL;
                end
                ST_FILL:
                begin
                    dst_reg <= dst_reg + ADDR_W'(1);
                    if (dst_reg == total_m1_reg)
                        state_reg <= ST_LOC;
                end
                ST_READ_ADDR:
                begin
                    state_reg <= ST_READ_WAIT;
                end
                ST_READ_WAIT:
                begin
                    cell_reg  <= ram_rdata;
                    state_reg <= ST_LOC;
                end
                ST_LOC:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result word: shown for the single RESULT cycle
    // ------------------------------------------------------------------
    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_RESULT);
    assign cursor_x        = POS_X_W'(col_reg);
    assign cursor_y        = POS_Y_W'(row_reg);
    assign cursor_location = LOC_W'(mac_q);
    assign cell_word       = cell_reg;
    assign scrolled        = scrolled_reg;

`ifndef SYNTHESIS
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe held longer than one cycle");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("screen memory written while idle");

    a_copy_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == ST_COPY || state_reg == ST_DRAIN))
        else $error("scroll copy write outside the copy phase");
`endif

endmodule
